>>> hw/rtl/ik_pole_direction_solver_macros.svh
// Assertion macros for the two-bone pole direction solver.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef IK_POLE_DIRECTION_SOLVER_MACROS_SVH
`define IK_POLE_DIRECTION_SOLVER_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset
`define IKP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ik pole solver check failed");

// Next-cycle implication, clocked on clk_i, off during reset
`define IKP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ik pole solver check failed");

`endif

>>> hw/rtl/ikp_pkg.sv
// Shared widths, constants and vector types of the pole direction solver.
// No dependencies; the top level, ikp_norm, ikp_proj and ikp_reach refer to it.
`timescale 1ns / 1ps
package ikp_pkg;

  localparam int COMP_W    = 21;               // packed Q5.15 component
  localparam int NORM_W    = 24;               // vector width at a normalizer input
  localparam int DIR_W     = 17;               // unit component, -32768..32768
  localparam int SQRT_W    = NORM_W + 7;       // root bits of len2 << 12
  localparam int DIV_Q_W   = 17;               // quotient bits per component
  localparam int NUM_W     = NORM_W + 22;      // dividend width
  localparam int NORM_LAT  = SQRT_W + DIV_Q_W + 4;
  localparam int PROJ_LAT  = 6;
  localparam int REACH_LAT = 4;

  localparam int ONE_Q15   = 32768;
  localparam int EPS_LEN2  = 10;
  localparam int EPS_LEN   = 3;
  localparam int UP_LIMIT  = 29491;
  localparam int RND_SHIFT = 30;

  typedef logic signed [NORM_W-1:0] nvec_t [3];
  typedef logic signed [DIR_W-1:0]  dvec_t [3];

endpackage

>>> hw/rtl/ik_pole_direction_solver.sv
// Top level of the two-bone pole direction solver.
// Uses ikp_pkg, ikp_norm, ikp_proj, ikp_reach, ikp_delay and the macro header.
//
// Usage: one pose query per input beat (root, target, rest middle joint,
// hint, prior direction with its valid bit, two bone lengths); one result
// beat per query (unit pole direction, pole point, fallback flag, reach flag).
// Both channels use valid/stall: a beat moves on an edge where valid is
// high and stall is low.
// A query passes, from the accepting edge to the result on the output,
// through an input stage, three normalizers in series (each: 31 square
// root stages, 17 division stages, four more), a 6-stage projection
// and two output stages.
// Throughput is one query per cycle; every stage takes a new beat each
// cycle while the output is not stalled.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall_o rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits; no result is shown until a query has
// passed the full pipeline.
`timescale 1ns / 1ps
`include "ik_pole_direction_solver_macros.svh"
module ik_pole_direction_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [62:0] root_pos_i,
  input  logic [62:0] target_pos_i,
  input  logic [62:0] rest_mid_pos_i,
  input  logic [62:0] hint_pos_i,
  input  logic [62:0] prior_dir_i,
  input  logic        prior_dir_valid_i,
  input  logic [19:0] upper_len_i,
  input  logic [19:0] lower_len_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [62:0] pole_dir_o,
  output logic [62:0] pole_point_o,
  output logic        used_fallback_o,
  output logic        reach_limited_o
);

  localparam int NW  = ikp_pkg::NORM_W;
  localparam int DRW = ikp_pkg::DIR_W;
  localparam int CPW = ikp_pkg::COMP_W;
  localparam int LN  = ikp_pkg::NORM_LAT;
  localparam int LP  = ikp_pkg::PROJ_LAT;
  localparam int LR  = ikp_pkg::REACH_LAT;
  localparam int TOT = 3 * LN + LP + 2;

  function automatic logic signed [CPW-1:0] comp_of(input logic [62:0] w,
                                                     input int unsigned k);
    comp_of = w[CPW*k +: CPW];
  endfunction

  // pipeline enable and valid chain
  logic         en;
  logic [TOT:0] vld_q;

  assign en          = !(vld_q[TOT] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[TOT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOT-1:0], in_valid_i};
    end
  end

  // input stage: unpack and form offsets from the root
  logic [62:0]    root_raw_q, prior_q;
  logic           pv_q;
  logic [19:0]    u_q, l_q;
  ikp_pkg::nvec_t tv_q, rest_q, hv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int unsigned k = 0; k < 3; k++) begin
        tv_q[k]   <= NW'(comp_of(target_pos_i, k)) - NW'(comp_of(root_pos_i, k));
        rest_q[k] <= NW'(comp_of(rest_mid_pos_i, k)) - NW'(comp_of(root_pos_i, k));
        hv_q[k]   <= NW'(comp_of(hint_pos_i, k)) - NW'(comp_of(root_pos_i, k));
      end
      root_raw_q <= root_pos_i;
      prior_q    <= prior_dir_i;
      pv_q       <= prior_dir_valid_i;
      u_q        <= upper_len_i;
      l_q        <= lower_len_i;
    end
  end

  // axis candidates
  ikp_pkg::dvec_t n1_dir, n2_dir;
  logic           n1_ok, n2_ok;
  logic           lim_r;

  ikp_norm u_norm_tgt (
    .clk_i (clk_i), .en_i (en), .vec_i (tv_q), .dir_o (n1_dir), .ok_o (n1_ok)
  );

  ikp_norm u_norm_rest (
    .clk_i (clk_i), .en_i (en), .vec_i (rest_q), .dir_o (n2_dir), .ok_o (n2_ok)
  );

  ikp_reach u_reach (
    .clk_i       (clk_i),
    .en_i        (en),
    .tv_i        (tv_q),
    .upper_len_i (u_q),
    .lower_len_i (l_q),
    .limited_o   (lim_r)
  );

  // align hint and rest offsets with the axis
  logic [3*NW-1:0] hv_dl, rest_dl;
  ikp_pkg::nvec_t  hv_a, rest_a;

  ikp_delay #(.W(3 * NW), .D(LN)) u_dly_hv (
    .clk_i (clk_i), .en_i (en), .d_i ({hv_q[2], hv_q[1], hv_q[0]}), .q_o (hv_dl)
  );

  ikp_delay #(.W(3 * NW), .D(LN)) u_dly_rest (
    .clk_i (clk_i), .en_i (en), .d_i ({rest_q[2], rest_q[1], rest_q[0]}),
    .q_o (rest_dl)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hv_a[k]   = hv_dl[NW*k +: NW];
      rest_a[k] = rest_dl[NW*k +: NW];
    end
  end

  // choose the axis and the up vector
  ikp_pkg::dvec_t axis;
  ikp_pkg::nvec_t up;
  logic           y_small;

  always_comb begin
    if (n1_ok) begin
      axis = n1_dir;
    end else if (n2_ok) begin
      axis = n2_dir;
    end else begin
      axis[0] = DRW'(ikp_pkg::ONE_Q15);
      axis[1] = '0;
      axis[2] = '0;
    end
  end

  assign y_small = (axis[1] <= $signed(DRW'(ikp_pkg::UP_LIMIT))) &&
                   (axis[1] >= -$signed(DRW'(ikp_pkg::UP_LIMIT)));

  always_comb begin
    up[0] = y_small ? '0 : NW'(ikp_pkg::ONE_Q15);
    up[1] = y_small ? NW'(ikp_pkg::ONE_Q15) : '0;
    up[2] = '0;
  end

  // project hint, rest and up onto the plane
  ikp_pkg::nvec_t ph, pr, pu;

  ikp_proj u_proj_hint (.clk_i (clk_i), .en_i (en), .a_i (axis), .c_i (hv_a), .p_o (ph));
  ikp_proj u_proj_rest (.clk_i (clk_i), .en_i (en), .a_i (axis), .c_i (rest_a), .p_o (pr));
  ikp_proj u_proj_up   (.clk_i (clk_i), .en_i (en), .a_i (axis), .c_i (up), .p_o (pu));

  ikp_pkg::dvec_t n3_dir, n4_dir, n5_dir;
  logic           n3_ok, n4_ok, n5_ok;

  ikp_norm u_norm_hint (
    .clk_i (clk_i), .en_i (en), .vec_i (ph), .dir_o (n3_dir), .ok_o (n3_ok)
  );

  ikp_norm u_norm_prest (
    .clk_i (clk_i), .en_i (en), .vec_i (pr), .dir_o (n4_dir), .ok_o (n4_ok)
  );

  ikp_norm u_norm_pup (
    .clk_i (clk_i), .en_i (en), .vec_i (pu), .dir_o (n5_dir), .ok_o (n5_ok)
  );

  // align prior direction with the hint result
  logic [62:0] prior_dl;
  logic        pv_dl;

  ikp_delay #(.W(64), .D(2 * LN + LP)) u_dly_prior (
    .clk_i (clk_i), .en_i (en), .d_i ({pv_q, prior_q}), .q_o ({pv_dl, prior_dl})
  );

  // fallback chain and candidate direction
  ikp_pkg::dvec_t fb_dir;
  ikp_pkg::nvec_t cand;

  always_comb begin
    if (n4_ok) begin
      fb_dir = n4_dir;
    end else if (n5_ok) begin
      fb_dir = n5_dir;
    end else begin
      fb_dir[0] = '0;
      fb_dir[1] = '0;
      fb_dir[2] = DRW'(ikp_pkg::ONE_Q15);
    end
  end

  always_comb begin
    for (int unsigned k = 0; k < 3; k++) begin
      if (n3_ok) begin
        cand[k] = NW'(n3_dir[k]);
      end else if (pv_dl) begin
        cand[k] = NW'(comp_of(prior_dl, k));
      end else begin
        cand[k] = NW'(fb_dir[k]);
      end
    end
  end

  ikp_pkg::dvec_t n6_dir;
  logic           n6_ok;

  ikp_norm u_norm_cand (
    .clk_i (clk_i), .en_i (en), .vec_i (cand), .dir_o (n6_dir), .ok_o (n6_ok)
  );

  // carry the fallback direction and flag past the last normalizer
  logic [3*DRW-1:0] fbd_dl;
  logic             fb_dl;
  ikp_pkg::dvec_t   fbd_a;

  ikp_delay #(.W(3 * DRW + 1), .D(LN)) u_dly_fb (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({!n3_ok, fb_dir[2], fb_dir[1], fb_dir[0]}),
    .q_o   ({fb_dl, fbd_dl})
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fbd_a[k] = fbd_dl[DRW*k +: DRW];
    end
  end

  // carry root and reach flag to the selection stage
  logic [62:0] root_dl;
  logic        lim_dl;

  ikp_delay #(.W(63), .D(3 * LN + LP)) u_dly_root (
    .clk_i (clk_i), .en_i (en), .d_i (root_raw_q), .q_o (root_dl)
  );

  ikp_delay #(.W(1), .D(3 * LN + LP - LR)) u_dly_lim (
    .clk_i (clk_i), .en_i (en), .d_i (lim_r), .q_o (lim_dl)
  );

  // select the final direction
  ikp_pkg::dvec_t dir_q;
  logic [62:0]    root_s_q;
  logic           fb_q, lim_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dir_q[k] <= n6_ok ? n6_dir[k] : fbd_a[k];
      end
      root_s_q <= root_dl;
      fb_q     <= fb_dl;
      lim_q    <= lim_dl;
    end
  end

  // pole point: root plus rounded quarter direction, saturated
  logic [DRW-1:0]      dmag [3];
  logic [DRW-1:0]      qt [3];
  logic signed [21:0]  psum [3];
  logic [CPW-1:0]      pt [3];

  always_comb begin
    for (int unsigned k = 0; k < 3; k++) begin
      dmag[k] = dir_q[k][DRW-1] ? DRW'(-dir_q[k]) : DRW'(dir_q[k]);
      qt[k]   = (dmag[k] + DRW'(2)) >> 2;
      psum[k] = 22'(comp_of(root_s_q, k)) +
                (dir_q[k][DRW-1] ? -$signed(22'(qt[k])) : $signed(22'(qt[k])));
      if (psum[k] > 22'sd1048575) begin
        pt[k] = 21'h0FFFFF;
      end else if (psum[k] < -22'sd1048576) begin
        pt[k] = 21'h100000;
      end else begin
        pt[k] = psum[k][CPW-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      pole_dir_o      <= {CPW'(dir_q[2]), CPW'(dir_q[1]), CPW'(dir_q[0])};
      pole_point_o    <= {pt[2], pt[1], pt[0]};
      used_fallback_o <= fb_q;
      reach_limited_o <= lim_q;
    end
  end

  // back-pressure only comes from a stalled result
  `IKP_ASSERT_IMP(a_stall_src, in_stall_o, out_valid_o && out_stall_i)
  // an accepted beat lands in the input stage
  `IKP_ASSERT_NXT(a_accept_lands, in_valid_i && !in_stall_o, vld_q[0])
  // the direction stays within one in its first and last components
  `IKP_ASSERT_IMP(a_dir_range, out_valid_o,
    ($signed(pole_dir_o[20:0]) <= 21'sd32768) &&
    ($signed(pole_dir_o[20:0]) >= -21'sd32768) &&
    ($signed(pole_dir_o[62:42]) <= 21'sd32768) &&
    ($signed(pole_dir_o[62:42]) >= -21'sd32768))

endmodule

>>> hw/rtl/ikp_delay.sv
// Enable-gated shift line that keeps side data aligned with the pipeline.
// Depends on nothing; depth and width are set by the instance.
`timescale 1ns / 1ps
module ikp_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [D];

  // advance one tap per enabled cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < D; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[D-1];

endmodule

>>> hw/rtl/ikp_norm.sv
// Pipelined vector normalizer: squares, sum, bit-serial square root,
// restoring division per component, clamp. Uses ikp_pkg.
`timescale 1ns / 1ps
module ikp_norm (
  input  logic          clk_i,
  input  logic          en_i,
  input  ikp_pkg::nvec_t vec_i,
  output ikp_pkg::dvec_t dir_o,
  output logic          ok_o
);

  localparam int NW  = ikp_pkg::NORM_W;
  localparam int SW  = ikp_pkg::SQRT_W;
  localparam int XW  = 2 * SW;
  localparam int L2W = 2 * NW + 2;
  localparam int SQW = 2 * NW;
  localparam int QW  = ikp_pkg::DIV_Q_W;
  localparam int MW  = ikp_pkg::NUM_W;
  localparam int CW  = SW + QW;
  localparam int RW  = SW + 3;
  localparam int DW  = ikp_pkg::DIR_W;

  typedef struct packed {
    logic [2:0][NW-1:0] mag;
    logic [2:0]         neg;
    logic               ok;
  } nside_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       ok;
  } dside_t;

  // square each component
  logic signed [SQW-1:0] sqs [3];
  logic [SQW-1:0]        sq_q [3];
  nside_t                s1_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sqs[k] = SQW'(vec_i[k]) * SQW'(vec_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k]       <= $unsigned(sqs[k]);
        s1_q.neg[k]   <= vec_i[k][NW-1];
        s1_q.mag[k]   <= vec_i[k][NW-1] ? NW'(-vec_i[k]) : NW'(vec_i[k]);
      end
      s1_q.ok <= 1'b0;
    end
  end

  // sum the squares and flag a degenerate length
  logic [L2W-1:0] len2;
  logic [XW-1:0]  x2_q;
  nside_t         s2_q;

  assign len2 = L2W'(sq_q[0]) + L2W'(sq_q[1]) + L2W'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q     <= {len2, 12'b0};
      s2_q.mag <= s1_q.mag;
      s2_q.neg <= s1_q.neg;
      s2_q.ok  <= len2 > L2W'(ikp_pkg::EPS_LEN2);
    end
  end

  // square root, one result bit per stage
  logic [SW-1:0] rt_q [SW];
  logic [RW-1:0] rm_q [SW];
  logic [XW-1:0] xs_q [SW];
  nside_t        ss_q [SW];

  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    logic [SW-1:0] rt_in;
    logic [RW-1:0] rm_in;
    logic [XW-1:0] x_in;
    nside_t        sd_in;
    logic [RW-1:0] trial;
    logic [RW-1:0] tst;

    if (j == 0) begin : g_first
      assign rt_in = '0;
      assign rm_in = '0;
      assign x_in  = x2_q;
      assign sd_in = s2_q;
    end else begin : g_next
      assign rt_in = rt_q[j-1];
      assign rm_in = rm_q[j-1];
      assign x_in  = xs_q[j-1];
      assign sd_in = ss_q[j-1];
    end

    assign trial = {rm_in[RW-3:0], x_in[2*(SW-1-j) +: 2]};
    assign tst   = {1'b0, rt_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (trial >= tst) begin
          rm_q[j] <= trial - tst;
          rt_q[j] <= {rt_in[SW-2:0], 1'b1};
        end else begin
          rm_q[j] <= trial;
          rt_q[j] <= {rt_in[SW-2:0], 1'b0};
        end
        xs_q[j] <= x_in;
        ss_q[j] <= sd_in;
      end
    end
  end

  // form rounded dividends |v| * 2^21 + L/2
  logic [SW-1:0] len;
  logic [CW-1:0] dp_q [3];
  logic [SW-1:0] dl_p_q;
  dside_t        dsp_q;

  assign len = rt_q[SW-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        dp_q[k] <= CW'((MW'(ss_q[SW-1].mag[k]) << 21) + MW'(len >> 1));
      end
      dl_p_q    <= len;
      dsp_q.neg <= ss_q[SW-1].neg;
      dsp_q.ok  <= ss_q[SW-1].ok;
    end
  end

  // restoring division, one quotient bit per stage
  logic [CW-1:0] dr_q [QW][3];
  logic [QW-1:0] dq_q [QW][3];
  logic [SW-1:0] dl_q [QW];
  dside_t        ds_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [CW-1:0] r_in [3];
    logic [QW-1:0] q_in [3];
    logic [SW-1:0] l_in;
    dside_t        sd_in;
    logic [CW-1:0] dv;

    if (i == 0) begin : g_first
      assign r_in  = dp_q;
      assign q_in  = '{default: '0};
      assign l_in  = dl_p_q;
      assign sd_in = dsp_q;
    end else begin : g_next
      assign r_in  = dr_q[i-1];
      assign q_in  = dq_q[i-1];
      assign l_in  = dl_q[i-1];
      assign sd_in = ds_q[i-1];
    end

    assign dv = CW'(l_in) << (QW - 1 - i);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int k = 0; k < 3; k++) begin
          if (r_in[k] >= dv) begin
            dr_q[i][k] <= r_in[k] - dv;
            dq_q[i][k] <= q_in[k] | (QW'(1) << (QW - 1 - i));
          end else begin
            dr_q[i][k] <= r_in[k];
            dq_q[i][k] <= q_in[k];
          end
        end
        dl_q[i] <= l_in;
        ds_q[i] <= sd_in;
      end
    end
  end

  // clamp to one and restore the sign
  logic [QW-1:0] qc [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc[k] = (dq_q[QW-1][k] > QW'(ikp_pkg::ONE_Q15)) ? QW'(ikp_pkg::ONE_Q15)
                                                     : dq_q[QW-1][k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        dir_o[k] <= ds_q[QW-1].neg[k] ? DW'(-$signed(DW'(qc[k]))) : $signed(DW'(qc[k]));
      end
      ok_o <= ds_q[QW-1].ok;
    end
  end

endmodule

>>> hw/rtl/ikp_proj.sv
// Pipelined projection of a vector onto the plane normal to a unit axis:
// p = c - round(a * dot(c, a) / 2^30). Uses ikp_pkg.
`timescale 1ns / 1ps
module ikp_proj (
  input  logic           clk_i,
  input  logic           en_i,
  input  ikp_pkg::dvec_t a_i,
  input  ikp_pkg::nvec_t c_i,
  output ikp_pkg::nvec_t p_o
);

  localparam int NW  = ikp_pkg::NORM_W;
  localparam int DRW = ikp_pkg::DIR_W;
  localparam int PW  = NW + DRW;
  localparam int DTW = PW + 2;
  localparam int NPW = DRW + DTW;
  localparam int RS  = ikp_pkg::RND_SHIFT;
  localparam int QPW = NPW - RS;

  ikp_pkg::nvec_t        c1_q, c2_q, c3_q, c4_q, c5_q;
  ikp_pkg::dvec_t        a1_q, a2_q;
  logic signed [PW-1:0]  pr_q [3];
  logic signed [DTW-1:0] dot_q;
  logic signed [NPW-1:0] n_q [3];
  logic [NPW-1:0]        mag_q [3];
  logic [2:0]            neg4_q, neg5_q;
  logic [QPW-1:0]        q_q [3];

  // component products of c and a
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        pr_q[k] <= PW'(c_i[k]) * PW'(a_i[k]);
      end
      c1_q <= c_i;
      a1_q <= a_i;
    end
  end

  // dot product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot_q <= DTW'(pr_q[0]) + DTW'(pr_q[1]) + DTW'(pr_q[2]);
      c2_q  <= c1_q;
      a2_q  <= a1_q;
    end
  end

  // scale the axis by the dot product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        n_q[k] <= NPW'(a2_q[k]) * NPW'(dot_q);
      end
      c3_q <= c2_q;
    end
  end

  // take magnitudes for rounding half away from zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        neg4_q[k] <= n_q[k][NPW-1];
        mag_q[k]  <= n_q[k][NPW-1] ? NPW'(-n_q[k]) : NPW'(n_q[k]);
      end
      c4_q <= c3_q;
    end
  end

  // round and drop the fraction
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        q_q[k] <= QPW'((mag_q[k] + (NPW'(1) << (RS - 1))) >> RS);
      end
      neg5_q <= neg4_q;
      c5_q   <= c4_q;
    end
  end

  // subtract the axis part
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        p_o[k] <= neg5_q[k] ? c5_q[k] + $signed(NW'(q_q[k]))
                            : c5_q[k] - $signed(NW'(q_q[k]));
      end
    end
  end

endmodule

>>> hw/rtl/ikp_reach.sv
// Reach check: squared root-target distance against the squared band
// limits from the two bone lengths. Uses ikp_pkg.
`timescale 1ns / 1ps
module ikp_reach (
  input  logic           clk_i,
  input  logic           en_i,
  input  ikp_pkg::nvec_t tv_i,
  input  logic [19:0]    upper_len_i,
  input  logic [19:0]    lower_len_i,
  output logic           limited_o
);

  localparam int NW  = ikp_pkg::NORM_W;
  localparam int SQW = 2 * NW;
  localparam int L2W = 2 * NW + 2;

  logic signed [SQW-1:0] sqs [3];
  logic [SQW-1:0]        sq_q [3];
  logic [19:0]           ad_q;
  logic [20:0]           sm_q;
  logic [L2W-1:0]        d2_q, d2b_q;
  logic [20:0]           lo_q, hi_q;
  logic [41:0]           lo2_q, hi2_q;
  logic [20:0]           lo;
  logic signed [21:0]    mx;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sqs[k] = SQW'(tv_i[k]) * SQW'(tv_i[k]);
    end
  end

  // squares, length difference and sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= $unsigned(sqs[k]);
      end
      ad_q <= (upper_len_i > lower_len_i) ? upper_len_i - lower_len_i
                                          : lower_len_i - upper_len_i;
      sm_q <= 21'(upper_len_i) + 21'(lower_len_i);
    end
  end

  // band limits and squared distance
  assign lo = 21'(ad_q) + 21'(ikp_pkg::EPS_LEN);
  assign mx = $signed({1'b0, sm_q}) - 22'sd3;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2_q <= L2W'(sq_q[0]) + L2W'(sq_q[1]) + L2W'(sq_q[2]);
      lo_q <= lo;
      hi_q <= (mx > $signed({1'b0, lo})) ? mx[20:0] : lo;
    end
  end

  // square the limits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo2_q <= 42'(lo_q) * 42'(lo_q);
      hi2_q <= 42'(hi_q) * 42'(hi_q);
      d2b_q <= d2_q;
    end
  end

  // compare against the band
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      limited_o <= (d2b_q < L2W'(lo2_q)) || (d2b_q > L2W'(hi2_q));
    end
  end

endmodule
